FILE: src/vmpc_pkg.sv
`default_nettype none

package vmpc_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_KEY_LOW  = 3'd0;
	localparam logic [2:0] CFG_KEY_HIGH = 3'd1;
	localparam logic [2:0] CFG_KEY_LEN  = 3'd2;
	localparam logic [2:0] CFG_IV_LOW   = 3'd3;
	localparam logic [2:0] CFG_IV_HIGH  = 3'd4;
	localparam logic [2:0] CFG_IV_LEN   = 3'd5;

	localparam int unsigned BYTE_W = 8;

	// one access to the permutation memory: optional write plus a read
	typedef struct packed {
		logic              we;
		logic [BYTE_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic [BYTE_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

FILE: src/vmpc_perm_ram.sv
`default_nettype none

module vmpc_perm_ram (
	input  wire logic                       clk,
	input  wire vmpc_pkg::ram_req_t         req,
	output logic [vmpc_pkg::BYTE_W-1:0]     rdata_q
);

	logic [vmpc_pkg::BYTE_W-1:0] mem_q [256];

	// read returns the old contents when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

endmodule

`default_nettype wire

FILE: src/vmpc_stream_cipher.sv
`default_nettype none

// VMPC stream cipher with initialization vector.
// Configuration: write key, vector and lengths through cfg_valid/cfg_index/cfg_data
// while the block is idle; cfg_ready is always high.
// Input channel in_valid/in_ready carries data_in and first_of_message. A
// transaction with first_of_message set rebuilds the 256-entry permutation:
// an identity fill, then SCHEDULE_ROUNDS rounds over the key and as many over
// the vector, each round stepping through R_RJ, R_RS, R_W1 and R_W2.
// Each byte then costs 5 dependent passes through the single-port-read
// permutation memory; data_out is registered in K_R4 after K_RJ, K_RS, K_R2
// and K_R3, and the next byte is taken only once the block is back in idle.
// Output channel out_valid/out_ready holds data_out in a register; if the
// receiver stalls, the block parks the finished keystream byte and waits
// before taking the next input.
// Reset clears the control registers (lengths to 16, indexes to 0). The permutation
// is not cleared: the first transaction after reset must set first_of_message.
module vmpc_stream_cipher #(
	parameter int unsigned MAX_KEY_BYTES   = 16,
	parameter int unsigned MAX_IV_BYTES    = 16,
	parameter int unsigned SCHEDULE_ROUNDS = 768
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        first_of_message,
	input  wire logic [7:0]  data_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       data_out
);

	localparam int unsigned RW = $clog2(SCHEDULE_ROUNDS);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_FILL = 12'b000000000010,
		ST_R_RJ = 12'b000000000100,
		ST_R_RS = 12'b000000001000,
		ST_R_W1 = 12'b000000010000,
		ST_R_W2 = 12'b000000100000,
		ST_K_RJ = 12'b000001000000,
		ST_K_RS = 12'b000010000000,
		ST_K_R2 = 12'b000100000000,
		ST_K_R3 = 12'b001000000000,
		ST_K_R4 = 12'b010000000000,
		ST_HOLD = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [63:0] key_lo_q, key_hi_q, iv_lo_q, iv_hi_q;
	logic [4:0]  key_len_q, iv_len_q;

	logic [7:0]    s_q, n_q, fill_q;
	logic [RW-1:0] m_q;
	logic [3:0]    kidx_q;
	logic          pass_q;
	logic          out_valid_q;
	logic          fwd_q;

	logic [7:0] pn_q, ps_q, ks_q, data_q, data_out_q;

	logic [7:0]         rdata, rdata_fwd;
	vmpc_pkg::ram_req_t ram_req;

	logic [4:0]    key_len_eff, iv_len_eff, len_eff;
	logic [127:0]  src_bytes;
	logic [7:0]    kb;
	logic [RW-1:0] m_inc;
	logic          round_last, kidx_wrap, out_free;

	function automatic logic [4:0] clamp_len(input logic [4:0] len, input logic [4:0] maxlen);
		logic [4:0] r;
		r = len;
		if (len == 5'd0) begin
			r = 5'd1;
		end else if (len > maxlen) begin
			r = maxlen;
		end
		return r;
	endfunction

	assign key_len_eff = clamp_len(key_len_q, 5'(MAX_KEY_BYTES));
	assign iv_len_eff  = clamp_len(iv_len_q, 5'(MAX_IV_BYTES));
	assign len_eff     = pass_q ? iv_len_eff : key_len_eff;
	assign src_bytes   = pass_q ? {iv_hi_q, iv_lo_q} : {key_hi_q, key_lo_q};
	assign kb          = src_bytes[{kidx_q, 3'b000} +: 8];
	assign kidx_wrap   = (kidx_q == 4'(len_eff - 5'd1));
	assign m_inc       = m_q + RW'(1);
	assign round_last  = (m_q == RW'(SCHEDULE_ROUNDS - 1));
	assign out_free    = !out_valid_q || out_ready;
	// last round of a pass wrote entry 0 in the cycle the next step read it
	assign rdata_fwd   = fwd_q ? ps_q : rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;

	vmpc_perm_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rdata_q (rdata)
	);

	// memory access per state; a read issued here returns next cycle
	always_comb begin
		ram_req.we    = 1'b0;
		ram_req.waddr = n_q;
		ram_req.wdata = ps_q;
		ram_req.raddr = n_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_req.raddr = n_q;
			end
			ST_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = fill_q;
				ram_req.wdata = fill_q;
				ram_req.raddr = 8'd0;
			end
			ST_R_RJ: begin
				ram_req.raddr = s_q + rdata_fwd + kb;
			end
			ST_R_RS: begin
				ram_req.raddr = rdata;
			end
			ST_R_W1: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = s_q;
				ram_req.wdata = pn_q;
			end
			ST_R_W2: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = m_q[7:0];
				ram_req.wdata = ps_q;
				ram_req.raddr = round_last ? 8'd0 : m_inc[7:0];
			end
			ST_K_RJ: begin
				ram_req.raddr = s_q + rdata_fwd;
			end
			ST_K_RS: begin
				ram_req.raddr = rdata;
			end
			ST_K_R2: begin
				ram_req.raddr = rdata;
			end
			ST_K_R3: begin
				// swap's first half; this read still sees the pre-swap entry
				ram_req.raddr = rdata + 8'd1;
				ram_req.we    = 1'b1;
				ram_req.waddr = s_q;
				ram_req.wdata = pn_q;
			end
			ST_K_R4: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = n_q;
				ram_req.wdata = ps_q;
			end
			ST_HOLD: begin
				ram_req.raddr = n_q;
			end
			default: begin
				ram_req.raddr = n_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_lo_q    <= '0;
			key_hi_q    <= '0;
			key_len_q   <= 5'd16;
			iv_lo_q     <= '0;
			iv_hi_q     <= '0;
			iv_len_q    <= 5'd16;
			s_q         <= '0;
			n_q         <= '0;
			fill_q      <= '0;
			m_q         <= '0;
			kidx_q      <= '0;
			pass_q      <= 1'b0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					vmpc_pkg::CFG_KEY_LOW:  key_lo_q  <= cfg_data;
					vmpc_pkg::CFG_KEY_HIGH: key_hi_q  <= cfg_data;
					vmpc_pkg::CFG_KEY_LEN:  key_len_q <= cfg_data[4:0];
					vmpc_pkg::CFG_IV_LOW:   iv_lo_q   <= cfg_data;
					vmpc_pkg::CFG_IV_HIGH:  iv_hi_q   <= cfg_data;
					vmpc_pkg::CFG_IV_LEN:   iv_len_q  <= cfg_data[4:0];
					default: ;
				endcase
			end

			fwd_q <= (state_q == ST_R_W2) && round_last && (m_q[7:0] == 8'd0);

			// K_R4 and HOLD load a new result whenever the old one leaves
			if (out_valid_q && out_ready && state_q != ST_K_R4 && state_q != ST_HOLD) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (first_of_message) begin
							state_q <= ST_FILL;
							fill_q  <= '0;
							s_q     <= '0;
							m_q     <= '0;
							kidx_q  <= '0;
							pass_q  <= 1'b0;
						end else begin
							state_q <= ST_K_RJ;
						end
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + 8'd1;
					if (fill_q == 8'hFF) begin
						state_q <= ST_R_RJ;
					end
				end
				ST_R_RJ: state_q <= ST_R_RS;
				ST_R_RS: begin
					s_q     <= rdata;
					state_q <= ST_R_W1;
				end
				ST_R_W1: state_q <= ST_R_W2;
				ST_R_W2: begin
					if (round_last) begin
						m_q    <= '0;
						kidx_q <= '0;
						if (!pass_q) begin
							pass_q  <= 1'b1;
							state_q <= ST_R_RJ;
						end else begin
							n_q     <= '0;
							state_q <= ST_K_RJ;
						end
					end else begin
						kidx_q  <= kidx_wrap ? 4'd0 : kidx_q + 4'd1;
						m_q     <= m_inc;
						state_q <= ST_R_RJ;
					end
				end
				ST_K_RJ: state_q <= ST_K_RS;
				ST_K_RS: begin
					s_q     <= rdata;
					state_q <= ST_K_R2;
				end
				ST_K_R2: state_q <= ST_K_R3;
				ST_K_R3: state_q <= ST_K_R4;
				ST_K_R4: begin
					n_q <= n_q + 8'd1;
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			data_q <= data_in;
		end
		if (state_q == ST_R_RJ || state_q == ST_K_RJ) begin
			pn_q <= rdata_fwd;
		end
		if (state_q == ST_R_W1 || state_q == ST_K_R2) begin
			ps_q <= rdata;
		end
		if (state_q == ST_K_R4) begin
			ks_q <= rdata;
			if (out_free) begin
				data_out_q <= data_q ^ rdata;
			end
		end
		if (state_q == ST_HOLD && out_free) begin
			data_out_q <= data_q ^ ks_q;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_HOLD) |-> !ram_req.we)
		else $error("permutation written while waiting");

	a_rekey_starts_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && first_of_message) |=> (state_q == ST_FILL))
		else $error("rekey transaction did not start the fill");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_K_R4 || $past(state_q) == ST_HOLD))
		else $error("result produced outside the keystream step");

endmodule

`default_nettype wire
